/* rtl/mrd_pkg.sv */
`timescale 1ns / 1ps

package mrd_pkg;

  localparam int MAX_FRAME  = 256;
  localparam int MAX_REGS   = 32;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 6;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = $clog2(MAX_FRAME + 1);
  localparam int AW         = $clog2(MAX_FRAME);
  localparam int HALF_DEPTH = MAX_FRAME / 2;
  localparam int HALF_AW    = $clog2(HALF_DEPTH);
  localparam int BANKS      = 2;
  localparam int BANK_DEPTH = BANKS * HALF_DEPTH;

  localparam int JOBQ_DEPTH = BANKS;
  localparam int JOBQ_PW    = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

  localparam logic [WORD_W-1:0]  CRC_INIT   = 16'hFFFF;
  localparam logic [WORD_W-1:0]  CRC_POLY   = 16'hA001;
  localparam int                 MIN_LEN    = 5;
  localparam logic [COUNT_W-1:0] COUNT_RST  = 6'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CRC   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_COUNT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd4;

  typedef struct packed {
    logic                bank;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } job_t;

  typedef struct packed {
    logic              en;
    logic              bank;
    logic [AW-1:0]     addr;
    logic [BYTE_W-1:0] data;
  } wr_t;

  // one byte through the reflected crc-16, lsb first
  function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {{(WORD_W - BYTE_W){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/mrd_front.sv */
`timescale 1ns / 1ps

module mrd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mrd_pkg::BYTE_W-1:0]   in_rx_byte,
  input  logic                         in_end_of_frame,
  input  logic [mrd_pkg::COUNT_W-1:0]  expected_count,
  input  logic                         q_full,
  output logic                         push,
  output mrd_pkg::job_t                push_job,
  output mrd_pkg::wr_t                 wr
);

  logic [mrd_pkg::CNT_W-1:0]  cnt_r;
  logic [mrd_pkg::WORD_W-1:0] crc_r;
  logic [mrd_pkg::WORD_W-1:0] held_r;
  logic                       ovf_r;
  logic                       wbank_r;
  logic [mrd_pkg::BYTE_W-1:0] byte2_r;

  logic                       accept;
  logic                       room;
  logic [mrd_pkg::CNT_W-1:0]  n_nxt;
  logic [mrd_pkg::WORD_W-1:0] crc_nxt;
  logic [mrd_pkg::WORD_W-1:0] held_nxt;
  logic [mrd_pkg::WORD_W-1:0] rx_crc;
  logic                       ovf_nxt;
  logic [9:0]                 need_len;
  logic [9:0]                 two_q;
  logic                       count_bad;
  logic [mrd_pkg::STATUS_W-1:0] status;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  assign room     = cnt_r < mrd_pkg::CNT_W'(mrd_pkg::MAX_FRAME);
  assign n_nxt    = room ? cnt_r + mrd_pkg::CNT_W'(1) : cnt_r;
  assign ovf_nxt  = ovf_r || !room;
  // the crc trails the input by two bytes so the trailer never enters it
  assign crc_nxt  = (cnt_r >= mrd_pkg::CNT_W'(2)) ?
                    mrd_pkg::crc_feed(crc_r, held_r[15:8]) : crc_r;
  assign held_nxt = {held_r[7:0], in_rx_byte};
  assign rx_crc   = {held_nxt[7:0], held_nxt[15:8]};

  assign two_q     = {3'b000, expected_count, 1'b0};
  assign need_len  = two_q + 10'(mrd_pkg::MIN_LEN);
  assign count_bad = (expected_count == '0)
                  || (expected_count > mrd_pkg::COUNT_W'(mrd_pkg::MAX_REGS))
                  || ({2'b00, byte2_r} != two_q)
                  || ({1'b0, n_nxt} < need_len);

  always_comb begin
    if (ovf_nxt) begin
      status = mrd_pkg::ST_OVER;
    end else if (n_nxt < mrd_pkg::CNT_W'(mrd_pkg::MIN_LEN)) begin
      status = mrd_pkg::ST_SHORT;
    end else if (rx_crc != crc_nxt) begin
      status = mrd_pkg::ST_CRC;
    end else if (count_bad) begin
      status = mrd_pkg::ST_COUNT;
    end else begin
      status = mrd_pkg::ST_OK;
    end
  end

  assign push            = accept && in_end_of_frame;
  assign push_job.bank   = wbank_r;
  assign push_job.status = status;
  assign push_job.count  = expected_count;

  assign wr.en   = accept && room;
  assign wr.bank = wbank_r;
  assign wr.addr = cnt_r[mrd_pkg::AW-1:0];
  assign wr.data = in_rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      crc_r   <= mrd_pkg::CRC_INIT;
      held_r  <= '0;
      ovf_r   <= 1'b0;
      wbank_r <= 1'b0;
    end else if (accept) begin
      if (in_end_of_frame) begin
        cnt_r   <= '0;
        crc_r   <= mrd_pkg::CRC_INIT;
        held_r  <= '0;
        ovf_r   <= 1'b0;
        wbank_r <= !wbank_r;
      end else begin
        cnt_r  <= n_nxt;
        crc_r  <= crc_nxt;
        held_r <= held_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cnt_r == mrd_pkg::CNT_W'(2)) begin
      byte2_r <= in_rx_byte;
    end
  end

endmodule

/* rtl/mrd_jobq.sv */
`timescale 1ns / 1ps

module mrd_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mrd_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output mrd_pkg::job_t head
);

  mrd_pkg::job_t                 slots [mrd_pkg::JOBQ_DEPTH];
  logic [mrd_pkg::JOBQ_PW-1:0]   wptr_r;
  logic [mrd_pkg::JOBQ_PW-1:0]   rptr_r;
  logic [mrd_pkg::JOBQ_CW-1:0]   count_r;
  logic                          do_push;
  logic                          do_pop;

  assign full       = count_r == mrd_pkg::JOBQ_CW'(mrd_pkg::JOBQ_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = slots[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [mrd_pkg::JOBQ_PW-1:0] bump(input logic [mrd_pkg::JOBQ_PW-1:0] p);
    return (p == mrd_pkg::JOBQ_PW'(mrd_pkg::JOBQ_DEPTH - 1)) ? '0 : p + mrd_pkg::JOBQ_PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= bump(wptr_r);
      end
      if (do_pop) begin
        rptr_r <= bump(rptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + mrd_pkg::JOBQ_CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - mrd_pkg::JOBQ_CW'(1);
      end
    end
  end

endmodule

/* rtl/mrd_back.sv */
`timescale 1ns / 1ps

module mrd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mrd_pkg::wr_t                  wr,
  input  logic                          job_valid,
  input  mrd_pkg::job_t                 job,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mrd_pkg::WORD_W-1:0]    out_register_word,
  output logic [mrd_pkg::IDX_W-1:0]     out_word_index,
  output logic [mrd_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam int SAW = mrd_pkg::HALF_AW + 1;

  // odd byte addresses hold the high bytes, even ones the low bytes
  logic [mrd_pkg::BYTE_W-1:0] store_odd  [mrd_pkg::BANK_DEPTH];
  logic [mrd_pkg::BYTE_W-1:0] store_even [mrd_pkg::BANK_DEPTH];

  logic [1:0]                    state_r;
  logic [1:0]                    state_nxt;
  logic [mrd_pkg::IDX_W-1:0]     i_r;
  logic [mrd_pkg::BYTE_W-1:0]    hi_r;
  logic [mrd_pkg::BYTE_W-1:0]    lo_r;
  logic                          out_valid_r;
  logic [mrd_pkg::WORD_W-1:0]    out_word_r;
  logic [mrd_pkg::IDX_W-1:0]     out_index_r;
  logic [mrd_pkg::STATUS_W-1:0]  out_status_r;
  logic                          out_last_r;

  logic [SAW-1:0]                wr_addr;
  logic [SAW-1:0]                rd_odd_addr;
  logic [SAW-1:0]                rd_even_addr;
  logic                          is_last;
  logic                          taken;

  assign wr_addr      = {wr.bank, wr.addr[mrd_pkg::AW-1:1]};
  assign rd_odd_addr  = {job.bank, mrd_pkg::HALF_AW'(i_r) + mrd_pkg::HALF_AW'(1)};
  assign rd_even_addr = {job.bank, mrd_pkg::HALF_AW'(i_r) + mrd_pkg::HALF_AW'(2)};
  assign is_last      = (mrd_pkg::COUNT_W'(i_r) + mrd_pkg::COUNT_W'(1)) == job.count;
  assign taken        = out_valid_r && out_ready;
  assign pop          = taken && out_last_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.addr[0]) begin
        store_odd[wr_addr] <= wr.data;
      end else begin
        store_even[wr_addr] <= wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= store_odd[rd_odd_addr];
    lo_r <= store_even[rd_even_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          state_nxt = (job.status == mrd_pkg::ST_OK) ? S_READ : S_OUT;
        end
      end
      S_READ: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_OUT;
      S_OUT: begin
        if (taken) begin
          state_nxt = out_last_r ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      i_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && job_valid) begin
        i_r         <= '0;
        out_valid_r <= job.status != mrd_pkg::ST_OK;
      end else if (state_r == S_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (taken) begin
        out_valid_r <= 1'b0;
        i_r         <= i_r + mrd_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && job_valid) begin
      out_word_r   <= '0;
      out_index_r  <= '0;
      out_status_r <= job.status;
      out_last_r   <= 1'b1;
    end else if (state_r == S_LOAD) begin
      out_word_r   <= {hi_r, lo_r};
      out_index_r  <= i_r;
      out_status_r <= mrd_pkg::ST_OK;
      out_last_r   <= is_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_register_word = out_word_r;
  assign out_word_index    = out_index_r;
  assign out_status        = out_status_r;
  assign out_last          = out_last_r;

endmodule

/* rtl/modbus_rtu_response_deframer.sv */
`timescale 1ns / 1ps

// channel   | direction | ports                                         | beat
// ----------+-----------+-----------------------------------------------+---------------------
// in        | input     | in_valid/in_ready, in_rx_byte, in_end_of_frame| one received byte
// out       | output    | out_valid/out_ready, out_register_word,       | one register word or
//           |           | out_word_index, out_status, out_last          | one error result
// cfg       | input     | cfg_wr_en, cfg_wr_data                        | expected_count write
//
// a byte beat is taken when in_valid and in_ready are high; in_ready drops only while two
// frames wait in the job queue for the result side (each owns one bank of the frame store)
// a good frame gives one word at a time through the registered store read and the single
// output register, the next only once the last is taken; an error frame gives one beat
// rst_n is synchronous; the frame store has no reset and needs no clearing pass

module modbus_rtu_response_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mrd_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic                          in_end_of_frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mrd_pkg::WORD_W-1:0]    out_register_word,
  output logic [mrd_pkg::IDX_W-1:0]     out_word_index,
  output logic [mrd_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic [mrd_pkg::COUNT_W-1:0]   cfg_wr_data
);

  // expected register count, checked (doubled) against byte 2 at frame end
  logic [mrd_pkg::COUNT_W-1:0] expected_count_r;

  // front to queue
  logic          push;
  mrd_pkg::job_t push_job;
  logic          q_full;
  // queue to back
  logic          head_valid;
  mrd_pkg::job_t head;
  logic          pop;
  // front writes the frame store held by the back
  mrd_pkg::wr_t  wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_count_r <= mrd_pkg::COUNT_RST;
    end else if (cfg_wr_en) begin
      expected_count_r <= cfg_wr_data;
    end
  end

  // byte intake: crc, byte count, overflow and the frame end verdict
  mrd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .in_end_of_frame (in_end_of_frame),
    .expected_count  (expected_count_r),
    .q_full          (q_full),
    .push            (push),
    .push_job        (push_job),
    .wr              (wr)
  );

  // finished frames waiting for the result side
  mrd_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // result side: reads byte pairs from the store and drives the output register
  mrd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .wr                (wr),
    .job_valid         (head_valid),
    .job               (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_register_word (out_register_word),
    .out_word_index    (out_word_index),
    .out_status        (out_status),
    .out_last          (out_last)
  );

endmodule
